### hdl/rgbc_pkg.sv
package rgbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 12;
  localparam int ROW_W      = HGT_W + 1;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int COEF_BITS  = 16;
  localparam int COEF_FRAC  = 12;
  localparam int KERNEL_W   = 3 * COEF_BITS;
  localparam int PROD_W     = CH_W + 1 + COEF_BITS;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int TSUM_W     = PROD_W + 4;
  localparam int QUOT_W     = TSUM_W - 1 - COEF_FRAC;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CRED_W     = FIFO_AW + 1;
  localparam int CFG_IDX_W  = 3;

  localparam logic [WID_W-1:0]    WIDTH_RESET  = 11'd640;
  localparam logic [HGT_W-1:0]    HEIGHT_RESET = 12'd480;
  // 0.1 in Q4.12 in each of the three slots
  localparam logic [KERNEL_W-1:0] KERNEL_RESET = 48'h019A_019A_019A;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [WID_W-1:0]   wid_t;
  typedef logic [HGT_W-1:0]   hgt_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [LINE_W-1:0]  line_t;
  typedef logic [CRED_W-1:0]  cred_t;
  typedef logic [FIFO_AW-1:0] fptr_t;

  typedef logic [8:0][PIX_W-1:0]     nbhd_t;
  typedef logic [8:0][COEF_BITS-1:0] kernel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            flush;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } pix_out_t;

  // control traveling with an item into the window stage
  typedef struct packed {
    logic valid;
    logic emit;
    logic pend;
    logic pad_left;
    logic pad_right;
    logic pad_top;
    logic pad_bot;
    logic last;
  } win_ctl_t;

  // control traveling with a neighborhood through the MAC pipe
  typedef struct packed {
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

### hdl/rgbc_line_mem.sv
module rgbc_line_mem (
  input  logic           clk,
  input  logic           rd_en,
  input  rgbc_pkg::col_t rd_addr,
  output rgbc_pkg::line_t rd_data,
  input  logic           wr_en,
  input  rgbc_pkg::col_t wr_addr,
  input  rgbc_pkg::line_t wr_data
);

  // word = {row two above, row one above}
  rgbc_pkg::line_t mem_r [rgbc_pkg::MAX_WIDTH];
  rgbc_pkg::line_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/rgbc_window.sv
module rgbc_window (
  input  logic               clk,
  input  logic               rst_n,
  input  rgbc_pkg::win_ctl_t ctl,
  input  rgbc_pkg::pix_t     pix,
  input  rgbc_pkg::pix_t     top,
  input  rgbc_pkg::pix_t     mid,
  output rgbc_pkg::nbhd_t    nb,
  output rgbc_pkg::mac_ctl_t nb_ctl
);

  rgbc_pkg::nbhd_t    win_r;
  rgbc_pkg::nbhd_t    win_nxt;
  rgbc_pkg::nbhd_t    sel;
  rgbc_pkg::nbhd_t    nb_r;
  rgbc_pkg::mac_ctl_t nb_ctl_r;

  always_comb begin
    for (int y = 0; y < 3; y++) begin
      win_nxt[y*3+0] = win_r[y*3+1];
      win_nxt[y*3+1] = win_r[y*3+2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = pix;

    // pending center = last pixel of a row, taken before the shift
    if (ctl.pend) begin
      for (int y = 0; y < 3; y++) begin
        sel[y*3+0] = win_r[y*3+1];
        sel[y*3+1] = win_r[y*3+2];
        sel[y*3+2] = '0;
      end
    end else begin
      sel = win_nxt;
    end

    if (ctl.pad_left) begin
      sel[0] = '0; sel[3] = '0; sel[6] = '0;
    end
    if (ctl.pad_right) begin
      sel[2] = '0; sel[5] = '0; sel[8] = '0;
    end
    if (ctl.pad_top) begin
      sel[0] = '0; sel[1] = '0; sel[2] = '0;
    end
    if (ctl.pad_bot) begin
      sel[6] = '0; sel[7] = '0; sel[8] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      nb_ctl_r <= '0;
    end else begin
      if (ctl.valid) begin
        win_r <= win_nxt;
      end
      nb_ctl_r.valid <= ctl.valid && ctl.emit;
      nb_ctl_r.last  <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    nb_r <= sel;
  end

  assign nb     = nb_r;
  assign nb_ctl = nb_ctl_r;

endmodule

### hdl/rgbc_mac.sv
module rgbc_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  rgbc_pkg::nbhd_t    nb,
  input  rgbc_pkg::mac_ctl_t nb_ctl,
  input  rgbc_pkg::kernel_t  kern,
  output rgbc_pkg::pix_out_t res,
  output logic               res_valid
);

  logic signed [rgbc_pkg::PROD_W-1:0] prod_nxt [3][9];
  logic signed [rgbc_pkg::PROD_W-1:0] prod_r   [3][9];
  logic signed [rgbc_pkg::RSUM_W-1:0] rsum_nxt [3][3];
  logic signed [rgbc_pkg::RSUM_W-1:0] rsum_r   [3][3];
  logic signed [rgbc_pkg::TSUM_W-1:0] tsum     [3];
  logic        [rgbc_pkg::QUOT_W-1:0] quot     [3];
  logic        [rgbc_pkg::CH_W-1:0]   chan     [3];

  rgbc_pkg::mac_ctl_t a_ctl_r;
  rgbc_pkg::mac_ctl_t b_ctl_r;
  rgbc_pkg::pix_out_t res_r;
  logic               res_valid_r;

  // stage A: one 9x16 signed product per tap and channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        prod_nxt[ch][i] = $signed({1'b0, nb[i][ch*rgbc_pkg::CH_W +: rgbc_pkg::CH_W]})
                        * $signed(kern[i]);
      end
    end
  end

  // stage B: per-row sums
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int y = 0; y < 3; y++) begin
        rsum_nxt[ch][y] = rgbc_pkg::RSUM_W'(prod_r[ch][y*3+0])
                        + rgbc_pkg::RSUM_W'(prod_r[ch][y*3+1])
                        + rgbc_pkg::RSUM_W'(prod_r[ch][y*3+2]);
      end
    end
  end

  // stage C: total, drop fraction, clamp to 0..255
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tsum[ch] = rgbc_pkg::TSUM_W'(rsum_r[ch][0])
               + rgbc_pkg::TSUM_W'(rsum_r[ch][1])
               + rgbc_pkg::TSUM_W'(rsum_r[ch][2]);
      quot[ch] = tsum[ch][rgbc_pkg::TSUM_W-2:rgbc_pkg::COEF_FRAC];
      if (tsum[ch][rgbc_pkg::TSUM_W-1]) begin
        chan[ch] = '0;
      end else if (quot[ch] > rgbc_pkg::QUOT_W'(255)) begin
        chan[ch] = '1;
      end else begin
        chan[ch] = quot[ch][rgbc_pkg::CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rsum_r <= rsum_nxt;
    res_r.red_out   <= chan[0];
    res_r.green_out <= chan[1];
    res_r.blue_out  <= chan[2];
    res_r.frame_end <= b_ctl_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r     <= '0;
      b_ctl_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      a_ctl_r     <= nb_ctl;
      b_ctl_r     <= a_ctl_r;
      res_valid_r <= b_ctl_r.valid;
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

### hdl/rgbc_out_fifo.sv
module rgbc_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rgbc_pkg::pix_out_t push_data,
  input  logic               pop,
  output logic               valid,
  output rgbc_pkg::pix_out_t data
);

  rgbc_pkg::pix_out_t mem_r [rgbc_pkg::FIFO_DEPTH];
  rgbc_pkg::fptr_t    wr_ptr_r;
  rgbc_pkg::fptr_t    rd_ptr_r;
  rgbc_pkg::cred_t    cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign valid = (cnt_r != '0);
  assign data  = mem_r[rd_ptr_r];

endmodule

### hdl/rgb_conv3x3_zero_pad.sv
// 3x3 RGB convolution with zero padding. Takes one pixel per clock in raster
// order while in_ready is high and returns one filtered pixel per clock while
// out_ready is high: each channel is the sum of nine pixel*coefficient products
// (signed Q4.12), fraction dropped, clamped to 0..255. A result belongs to the
// pixel one row plus one pixel behind the input, so after the last pixel of a
// frame send image_width+1 transfers with flush set to drain the last row;
// frame_end marks the bottom-right result. Throughput is one item per cycle
// while in_ready is high, paced by the single read and single write port of
// the line memory (one read-modify-write per item). A result passes through
// stage 1, the window, MAC stages A-C and the output queue. in_ready stays
// low after reset while the 1024-word line memory is cleared. An 8-entry
// output queue with credit counting keeps accepting input while results wait;
// after the clear, in_ready drops only when 8 results are owed. Config writes
// are always ready and must only come while the block is idle.
module rgb_conv3x3_zero_pad (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rgbc_pkg::pix_in_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rgbc_pkg::pix_out_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbc_pkg::KERNEL_W-1:0]    cfg_data
);

  // ---------------------------------------------------------------- config
  rgbc_pkg::wid_t                 image_width_r;
  rgbc_pkg::hgt_t                 image_height_r;
  logic [rgbc_pkg::KERNEL_W-1:0]  kern_top_r;
  logic [rgbc_pkg::KERNEL_W-1:0]  kern_mid_r;
  logic [rgbc_pkg::KERNEL_W-1:0]  kern_bot_r;
  rgbc_pkg::kernel_t              kern;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= rgbc_pkg::WIDTH_RESET;
      image_height_r <= rgbc_pkg::HEIGHT_RESET;
      kern_top_r     <= rgbc_pkg::KERNEL_RESET;
      kern_mid_r     <= rgbc_pkg::KERNEL_RESET;
      kern_bot_r     <= rgbc_pkg::KERNEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (rgbc_pkg::cfg_idx_t'(cfg_index))
        rgbc_pkg::CFG_IMAGE_WIDTH:   image_width_r  <= cfg_data[rgbc_pkg::WID_W-1:0];
        rgbc_pkg::CFG_IMAGE_HEIGHT:  image_height_r <= cfg_data[rgbc_pkg::HGT_W-1:0];
        rgbc_pkg::CFG_KERNEL_TOP:    kern_top_r     <= cfg_data;
        rgbc_pkg::CFG_KERNEL_MIDDLE: kern_mid_r     <= cfg_data;
        rgbc_pkg::CFG_KERNEL_BOTTOM: kern_bot_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // tap order: row-major, top row first, left column in low bits of each reg
  always_comb begin
    for (int kx = 0; kx < 3; kx++) begin
      kern[kx]   = kern_top_r[kx*rgbc_pkg::COEF_BITS +: rgbc_pkg::COEF_BITS];
      kern[3+kx] = kern_mid_r[kx*rgbc_pkg::COEF_BITS +: rgbc_pkg::COEF_BITS];
      kern[6+kx] = kern_bot_r[kx*rgbc_pkg::COEF_BITS +: rgbc_pkg::COEF_BITS];
    end
  end

  // sizes in force; out-of-range settings are pinned to the legal range
  rgbc_pkg::wid_t w_eff;
  rgbc_pkg::hgt_t h_eff;
  rgbc_pkg::row_t h_ext;

  always_comb begin
    if (image_width_r < rgbc_pkg::wid_t'(2)) begin
      w_eff = rgbc_pkg::wid_t'(2);
    end else if (image_width_r > rgbc_pkg::wid_t'(rgbc_pkg::MAX_WIDTH)) begin
      w_eff = rgbc_pkg::wid_t'(rgbc_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width_r;
    end
    h_eff = (image_height_r < rgbc_pkg::hgt_t'(2)) ? rgbc_pkg::hgt_t'(2) : image_height_r;
    h_ext = rgbc_pkg::row_t'(h_eff);
  end

  // ------------------------------------------------- line memory clearing
  logic           clr_busy_r;
  rgbc_pkg::col_t clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == rgbc_pkg::col_t'(rgbc_pkg::MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------- position and handshake
  rgbc_pkg::col_t     col_r;
  rgbc_pkg::row_t     row_r;
  rgbc_pkg::cred_t    cred_r;
  logic               in_xfer;
  logic               out_xfer;

  rgbc_pkg::wid_t     c_a;
  rgbc_pkg::row_t     r_a;
  rgbc_pkg::wid_t     c_n;
  rgbc_pkg::row_t     r_n;
  rgbc_pkg::hgt_t     cr_e;
  rgbc_pkg::col_t     cc_e;
  logic               pend;
  logic               cur;
  rgbc_pkg::win_ctl_t s0_ctl;
  rgbc_pkg::pix_t     s0_pix;

  assign in_ready = !clr_busy_r && (cred_r < rgbc_pkg::cred_t'(rgbc_pkg::FIFO_DEPTH));
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    // position of this item, renormalized in case the size changed
    c_a = {1'b0, col_r};
    r_a = row_r;
    if (c_a >= w_eff) begin
      c_a = '0;
      r_a = row_r + 1'b1;
    end
    if (r_a > h_ext + rgbc_pkg::row_t'(1)) begin
      r_a = '0;
      c_a = '0;
    end

    // column 0 finishes the last pixel of the row two above;
    // other columns finish the pixel to the left in the row above
    pend = (c_a == '0) && (r_a >= rgbc_pkg::row_t'(2))
        && (r_a < h_ext + rgbc_pkg::row_t'(2));
    cur  = (c_a != '0) && (r_a >= rgbc_pkg::row_t'(1))
        && (r_a < h_ext + rgbc_pkg::row_t'(1));

    if (pend) begin
      cr_e = rgbc_pkg::hgt_t'(r_a - rgbc_pkg::row_t'(2));
      cc_e = rgbc_pkg::col_t'(w_eff - 1'b1);
    end else begin
      cr_e = rgbc_pkg::hgt_t'(r_a - rgbc_pkg::row_t'(1));
      cc_e = rgbc_pkg::col_t'(c_a - 1'b1);
    end

    s0_ctl.valid     = in_xfer;
    s0_ctl.emit      = pend || cur;
    s0_ctl.pend      = pend;
    s0_ctl.pad_left  = (cc_e == '0);
    s0_ctl.pad_right = ({1'b0, cc_e} == w_eff - 1'b1);
    s0_ctl.pad_top   = (cr_e == '0);
    s0_ctl.pad_bot   = (cr_e == h_eff - 1'b1);
    s0_ctl.last      = s0_ctl.emit && s0_ctl.pad_right && s0_ctl.pad_bot;

    c_n = c_a + 1'b1;
    r_n = r_a;
    if (c_n >= w_eff) begin
      c_n = '0;
      r_n = r_a + 1'b1;
    end
    if (s0_ctl.last) begin
      c_n = '0;
      r_n = '0;
    end

    s0_pix = in_data.flush ? '0 : {in_data.blue_in, in_data.green_in, in_data.red_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cred_r <= '0;
    end else begin
      if (in_xfer) begin
        col_r <= rgbc_pkg::col_t'(c_n);
        row_r <= r_n;
      end
      // one credit per result owed: in the pipe or waiting in the queue
      if ((in_xfer && s0_ctl.emit) && !out_xfer) begin
        cred_r <= cred_r + 1'b1;
      end else if (out_xfer && !(in_xfer && s0_ctl.emit)) begin
        cred_r <= cred_r - 1'b1;
      end
    end
  end

  // ------------------------------------------------------ stage 1 + memory
  rgbc_pkg::win_ctl_t s1_ctl_r;
  rgbc_pkg::pix_t     s1_pix_r;
  rgbc_pkg::col_t     s1_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s0_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r <= s0_pix;
    s1_col_r <= rgbc_pkg::col_t'(c_a);
  end

  rgbc_pkg::line_t mem_rd_data;
  rgbc_pkg::line_t mem_wr_data;
  rgbc_pkg::col_t  mem_wr_addr;
  logic            mem_wr_en;

  // consecutive items within a frame never share a column (width is at least
  // 2). The one exception is the frame end, where column 0 of the last drain
  // item is followed by column 0 of the next frame's first row: that read
  // sees the old word, which only ever lands on top-padded or dropped taps.
  always_comb begin
    if (clr_busy_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_r;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = s1_ctl_r.valid;
      mem_wr_addr = s1_col_r;
      mem_wr_data = {mem_rd_data[rgbc_pkg::PIX_W-1:0], s1_pix_r};
    end
  end

  rgbc_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (rgbc_pkg::col_t'(c_a)),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // ------------------------------------------------------- window and MAC
  rgbc_pkg::nbhd_t    nb;
  rgbc_pkg::mac_ctl_t nb_ctl;
  rgbc_pkg::pix_out_t res;
  logic               res_valid;

  rgbc_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (s1_ctl_r),
    .pix    (s1_pix_r),
    .top    (mem_rd_data[rgbc_pkg::LINE_W-1:rgbc_pkg::PIX_W]),
    .mid    (mem_rd_data[rgbc_pkg::PIX_W-1:0]),
    .nb     (nb),
    .nb_ctl (nb_ctl)
  );

  rgbc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .nb        (nb),
    .nb_ctl    (nb_ctl),
    .kern      (kern),
    .res       (res),
    .res_valid (res_valid)
  );

  rgbc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_xfer),
    .valid     (out_valid),
    .data      (out_data)
  );

  // ------------------------------------------------------------ checks
  a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= rgbc_pkg::cred_t'(rgbc_pkg::FIFO_DEPTH))
    else $error("more results owed than the output queue holds");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("input taken during line memory clear");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cred_r != '0))
    else $error("result shown with no credit outstanding");

  a_push_owed: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (cred_r != '0))
    else $error("result produced that was never owed");

endmodule
